// ===== rtl/core/zlhp_pkg.sv =====
// Package for the ZIP local header parser: header byte positions, signatures,
// error codes and port widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package zlhp_pkg;

    localparam int unsigned DataW  = 8;
    localparam int unsigned OutW   = 96;
    localparam int unsigned RegionW = 3;
    localparam int unsigned IdxW   = 5;

    localparam logic [31:0] HDR_SIG  = 32'h0403_4b50;
    localparam logic [31:0] DESC_SIG = 32'h0807_4b50;

    // Last byte of each little-endian header field, counted from zero.
    localparam logic [IdxW-1:0] POS_SIGNATURE = 5'd3;
    localparam logic [IdxW-1:0] POS_VERSION   = 5'd5;
    localparam logic [IdxW-1:0] POS_FLAGS     = 5'd7;
    localparam logic [IdxW-1:0] POS_METHOD    = 5'd9;
    localparam logic [IdxW-1:0] POS_CRC       = 5'd17;
    localparam logic [IdxW-1:0] POS_CSIZE     = 5'd21;
    localparam logic [IdxW-1:0] POS_USIZE     = 5'd25;
    localparam logic [IdxW-1:0] POS_NAME_LEN  = 5'd27;
    localparam logic [IdxW-1:0] POS_EXTRA_LEN = 5'd29;

    // Descriptor field ends, counted after an optional signature.
    localparam logic [IdxW-1:0] DESC_CRC_END   = 5'd4;
    localparam logic [IdxW-1:0] DESC_CSIZE_END = 5'd8;
    localparam logic [IdxW-1:0] DESC_USIZE_END = 5'd12;
    localparam logic [IdxW-1:0] DESC_SIG_LEN   = 5'd4;

    localparam logic [15:0] VERSION_RESET = 16'd20;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_SIG     = 2'd1;
    localparam logic [1:0] ERR_VERSION = 2'd2;
    localparam logic [1:0] ERR_EOB     = 2'd3;

    localparam logic [2:0] ADDR_MAX_VERSION = 3'd0;

endpackage

`default_nettype wire

// ===== rtl/core/zip_local_header_parser_core.sv =====
// ZIP local file record parser, top level.
// Depends on zlhp_pkg.
//
// Usage: raw archive bytes enter on the s_ stream, one byte per transaction,
// with s_tlast marking the last byte available in the buffer. Every input
// transaction produces exactly one output transaction on the m_ stream: the
// byte passed through, tagged with its region in m_tuser, plus the captured
// header fields and any error code. m_tlast is high on the final byte of a
// complete record, and only then do the three mismatch flags carry meaning.
// The result of an accepted byte is registered and shows on m_ in the next cycle.
// Throughput is one byte per cycle while the receiver does not stall: the whole parse
// step for a byte is a single pass of logic between the state registers and the output register.
// When the receiver stalls, the pending result holds in the output register;
// s_tready follows m_tready combinationally, so a byte is taken in the same
// cycle that the pending result leaves.
// After reset the parser expects the first header byte, max_version_needed reads 20
// and the output register is empty. The user writes the register over the APB port at
// byte address 0 only while the stream is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module zip_local_header_parser_core
    import zlhp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Input stream.
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [DataW-1:0]    s_tdata,   // [7:0] data_byte
    input  wire logic                s_tlast,   // end_of_buffer
    // Output stream.
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [OutW-1:0]          m_tdata,   // [7:0] byte_out, [9:8] error_code,
                                                // [10] crc_mismatch,
                                                // [11] compressed_size_mismatch,
                                                // [12] uncompressed_size_mismatch,
                                                // [13] encrypted, [29:14] method_code,
                                                // [61:30] crc_value,
                                                // [93:62] uncompressed_length, [95:94] zero
    output logic                     m_tlast,   // record_done
    output logic [RegionW-1:0]       m_tuser,   // [2:0] region
    // Configuration port.
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_NAME    = 3'd1,
        PH_EXTRA   = 3'd2,
        PH_DATA    = 3'd3,
        PH_DESC    = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [IdxW-1:0]    idx_reg, idx_next;
    logic [31:0]        skip_reg, skip_next;
    logic [31:0]        shift_reg, shift_next;
    logic               flag_enc_reg, flag_enc_next;
    logic               flag_desc_reg, flag_desc_next;
    logic [15:0]        method_reg, method_next;
    logic [31:0]        crc_reg, crc_next;
    logic [31:0]        csize_reg, csize_next;
    logic [31:0]        usize_reg, usize_next;
    logic [15:0]        name_len_reg, name_len_next;
    logic [15:0]        extra_len_reg, extra_len_next;
    logic [2:0]         mismatch_reg, mismatch_next;
    logic               has_sig_reg, has_sig_next;
    logic [15:0]        max_version_reg;

    logic               out_valid_reg;
    logic [OutW-1:0]    out_data_reg, out_data_next;
    logic               out_last_reg;
    logic [RegionW-1:0] out_user_reg, out_user_next;

    logic               accept;
    logic               cfg_write;
    logic [7:0]         in_byte;
    logic               in_eob;
    logic [31:0]        shifted;
    logic [RegionW-1:0] region;
    logic [1:0]         err;
    logic               done;
    logic               open_req;
    phase_t             open_from;
    logic               sig_now;
    logic [IdxW-1:0]    desc_pos;

    assign in_byte  = s_tdata[7:0];
    assign in_eob   = s_tlast;
    assign shifted  = {in_byte, shift_reg[31:8]};
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == ADDR_MAX_VERSION[2]);
    assign prdata    = (paddr[2] == ADDR_MAX_VERSION[2]) ? {16'd0, max_version_reg} : 32'd0;

    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        skip_next      = skip_reg;
        shift_next     = shift_reg;
        flag_enc_next  = flag_enc_reg;
        flag_desc_next = flag_desc_reg;
        method_next    = method_reg;
        crc_next       = crc_reg;
        csize_next     = csize_reg;
        usize_next     = usize_reg;
        name_len_next  = name_len_reg;
        extra_len_next = extra_len_reg;
        mismatch_next  = mismatch_reg;
        has_sig_next   = has_sig_reg;
        region         = phase_reg;
        err            = ERR_NONE;
        done           = 1'b0;
        open_req       = 1'b0;
        open_from      = PH_NAME;
        sig_now        = has_sig_reg;
        desc_pos       = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                shift_next = shifted;
                idx_next   = idx_reg + 5'd1;
                case (idx_reg)
                    POS_SIGNATURE:
                    begin
                        if (shifted != HDR_SIG)
                        begin
                            err        = ERR_SIG;
                            phase_next = PH_ERROR;
                        end
                    end
                    POS_VERSION:
                    begin
                        if (shifted[31:16] > max_version_reg)
                        begin
                            err        = ERR_VERSION;
                            phase_next = PH_ERROR;
                        end
                    end
                    POS_FLAGS:
                    begin
                        flag_enc_next  = shifted[16];
                        flag_desc_next = shifted[19];
                    end
                    POS_METHOD:    method_next   = shifted[31:16];
                    POS_CRC:       crc_next      = shifted;
                    POS_CSIZE:     csize_next    = shifted;
                    POS_USIZE:     usize_next    = shifted;
                    POS_NAME_LEN:  name_len_next = shifted[31:16];
                    POS_EXTRA_LEN:
                    begin
                        extra_len_next = shifted[31:16];
                        mismatch_next  = 3'b000;
                        open_req       = 1'b1;
                        open_from      = PH_NAME;
                    end
                    default: ;
                endcase
                if (phase_next == PH_ERROR)
                begin
                    idx_next = '0;
                end
            end
            PH_NAME, PH_EXTRA, PH_DATA:
            begin
                skip_next = skip_reg - 32'd1;
                if (skip_next == 32'd0)
                begin
                    open_req  = 1'b1;
                    open_from = phase_t'(phase_reg + 3'd1);
                end
            end
            PH_DESC:
            begin
                shift_next = shifted;
                if (idx_reg == POS_SIGNATURE)
                begin
                    sig_now = (shifted == DESC_SIG);
                end
                has_sig_next = sig_now;
                // Byte count within the CRC and size fields, past any signature.
                desc_pos = idx_reg + 5'd1;
                if (idx_reg >= POS_SIGNATURE && sig_now)
                begin
                    desc_pos = desc_pos - DESC_SIG_LEN;
                end
                if (idx_reg < POS_SIGNATURE)
                begin
                    desc_pos = '0;
                end
                idx_next = idx_reg + 5'd1;
                if (desc_pos == DESC_CRC_END)
                begin
                    if (shifted != crc_reg)
                    begin
                        mismatch_next[0] = 1'b1;
                    end
                end
                else if (desc_pos == DESC_CSIZE_END)
                begin
                    if (shifted != csize_reg)
                    begin
                        mismatch_next[1] = 1'b1;
                    end
                end
                else if (desc_pos == DESC_USIZE_END)
                begin
                    if (shifted != usize_reg)
                    begin
                        mismatch_next[2] = 1'b1;
                    end
                    phase_next = PH_HEADER;
                    idx_next   = '0;
                    shift_next = '0;
                    done       = 1'b1;
                end
            end
            default:
            begin
                region     = PH_ERROR;
                phase_next = PH_ERROR;
            end
        endcase

        // Move to the first nonempty region at or after open_from.
        if (open_req)
        begin
            if (open_from <= PH_NAME && name_len_next != 16'd0)
            begin
                phase_next = PH_NAME;
                skip_next  = {16'd0, name_len_next};
            end
            else if (open_from <= PH_EXTRA && extra_len_next != 16'd0)
            begin
                phase_next = PH_EXTRA;
                skip_next  = {16'd0, extra_len_next};
            end
            else if (open_from <= PH_DATA && csize_next != 32'd0)
            begin
                phase_next = PH_DATA;
                skip_next  = csize_next;
            end
            else if (open_from <= PH_DESC && flag_desc_next)
            begin
                phase_next = PH_DESC;
                idx_next   = '0;
                shift_next = '0;
            end
            else
            begin
                phase_next = PH_HEADER;
                idx_next   = '0;
                shift_next = '0;
                done       = 1'b1;
            end
        end

        if (in_eob)
        begin
            if (phase_next == PH_ERROR)
            begin
                phase_next = PH_HEADER;
                idx_next   = '0;
                shift_next = '0;
            end
            else if (!done && !(phase_next == PH_HEADER && idx_next == '0))
            begin
                if (err == ERR_NONE)
                begin
                    err = ERR_EOB;
                end
                phase_next = PH_HEADER;
                idx_next   = '0;
                shift_next = '0;
                skip_next  = '0;
            end
        end

        out_user_next = region;
        out_data_next = {2'b00, usize_next, crc_next, method_next, flag_enc_next,
                         mismatch_next & {3{done}}, err, in_byte};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            idx_reg         <= '0;
            skip_reg        <= '0;
            shift_reg       <= '0;
            flag_enc_reg    <= 1'b0;
            flag_desc_reg   <= 1'b0;
            method_reg      <= '0;
            crc_reg         <= '0;
            csize_reg       <= '0;
            usize_reg       <= '0;
            name_len_reg    <= '0;
            extra_len_reg   <= '0;
            mismatch_reg    <= '0;
            has_sig_reg     <= 1'b0;
            max_version_reg <= VERSION_RESET;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
            out_last_reg    <= 1'b0;
            out_user_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                max_version_reg <= pwdata[15:0];
            end
            if (accept)
            begin
                phase_reg     <= phase_next;
                idx_reg       <= idx_next;
                skip_reg      <= skip_next;
                shift_reg     <= shift_next;
                flag_enc_reg  <= flag_enc_next;
                flag_desc_reg <= flag_desc_next;
                method_reg    <= method_next;
                crc_reg       <= crc_next;
                csize_reg     <= csize_next;
                usize_reg     <= usize_next;
                name_len_reg  <= name_len_next;
                extra_len_reg <= extra_len_next;
                mismatch_reg  <= mismatch_next;
                has_sig_reg   <= has_sig_next;
                out_valid_reg <= 1'b1;
                out_data_reg  <= out_data_next;
                out_last_reg  <= done;
                out_user_reg  <= out_user_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    // A completed record never carries an error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[9:8] == ERR_NONE)
        else $error("record end reported together with an error");

    // A discarded byte never closes a record.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser != RegionW'(PH_ERROR))
        else $error("record end reported on a discarded byte");

    // Mismatch flags are only shown on the last byte of a record.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[12:10] == 3'b000)
        else $error("mismatch flag outside record end");

    // The discard state always leaves the field counter cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |-> idx_reg == '0)
        else $error("field counter not cleared in discard state");

    // A byte is taken only when the output register is free or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !out_valid_reg || m_tready)
        else $error("byte accepted over a stalled result");

endmodule

`default_nettype wire

// ===== tb/tb_zip_local_header_parser_core.sv =====
// Self-checking testbench for zip_local_header_parser_core: ZIP local records
// are streamed in byte by byte and every tagged byte is checked against a model.
// Depends on zlhp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb_zip_local_header_parser_core;
    import zlhp_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD = 300;
    localparam int CUT_NONE = -1;
    localparam int CUT_RANDOM = -2;

    typedef enum logic [2:0] {
        RGN_HEADER  = 3'd0,
        RGN_NAME    = 3'd1,
        RGN_EXTRA   = 3'd2,
        RGN_DATA    = 3'd3,
        RGN_DESC    = 3'd4,
        RGN_DISCARD = 3'd5
    } region_t;

    typedef struct packed {
        region_t     region;
        logic [7:0]  byte_out;
        logic        done;
        logic [1:0]  err;
        logic        crc_mm;
        logic        csize_mm;
        logic        usize_mm;
        logic        enc;
        logic [15:0] method;
        logic [31:0] crc;
        logic [31:0] usize;
    } byte_tag_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    typedef struct {
        logic [31:0] sig;
        logic [15:0] version;
        logic [15:0] flags;
        logic [15:0] method;
        logic [31:0] crc;
        logic [31:0] csize;
        logic [31:0] usize;
        logic [15:0] nlen;
        logic [15:0] elen;
        bit          desc_sig;
        logic [31:0] d_crc;
        logic [31:0] d_csize;
        logic [31:0] d_usize;
        int          cut_at;
        bit          eob_end;
    } record_spec_t;

    // Tracks the parser state for every accepted byte and holds the tags still due.
    class byte_tag_scoreboard;
        logic [15:0] max_version;
        region_t     phase;
        logic [4:0]  byte_idx;
        logic [31:0] skip_left;
        logic [31:0] shift_reg;
        logic [15:0] flags;
        logic [15:0] method;
        logic [15:0] version;
        logic [31:0] hdr_crc;
        logic [31:0] hdr_csize;
        logic [31:0] hdr_usize;
        logic [15:0] name_len;
        logic [15:0] extra_len;
        logic [2:0]  mismatch;
        logic        desc_sig_seen;
        byte_tag_t   tags_due[$];
        int          fault_count;

        function new();
            max_version = VERSION_RESET;
            phase = RGN_HEADER;
            byte_idx = '0;
            skip_left = '0;
            shift_reg = '0;
            flags = '0;
            method = '0;
            version = '0;
            hdr_crc = '0;
            hdr_csize = '0;
            hdr_usize = '0;
            name_len = '0;
            extra_len = '0;
            mismatch = '0;
            desc_sig_seen = 1'b0;
            fault_count = 0;
        endfunction

        function void flag_fault(string msg);
            fault_count++;
            if (fault_count <= 10)
                $display("%s", msg);
        endfunction

        function string show(byte_tag_t t);
            return $sformatf(
                {"region=%0d byte=%02h done=%0b err=%0d mm=%0b%0b%0b enc=%0b ",
                 "method=%04h crc=%08h usize=%08h"},
                t.region, t.byte_out, t.done, t.err, t.crc_mm, t.csize_mm, t.usize_mm,
                t.enc, t.method, t.crc, t.usize);
        endfunction

        // Enters the first nonempty region at or after 'from'; returns 1 when the
        // record has nothing left.
        function bit open_region(region_t from);
            if (from <= RGN_NAME && name_len != 0) begin
                phase = RGN_NAME;
                skip_left = {16'h0, name_len};
                return 1'b0;
            end
            if (from <= RGN_EXTRA && extra_len != 0) begin
                phase = RGN_EXTRA;
                skip_left = {16'h0, extra_len};
                return 1'b0;
            end
            if (from <= RGN_DATA && hdr_csize != 0) begin
                phase = RGN_DATA;
                skip_left = hdr_csize;
                return 1'b0;
            end
            if (from <= RGN_DESC && flags[3]) begin
                phase = RGN_DESC;
                byte_idx = '0;
                shift_reg = '0;
                return 1'b0;
            end
            phase = RGN_HEADER;
            byte_idx = '0;
            shift_reg = '0;
            return 1'b1;
        endfunction

        function void note_input_byte(logic [7:0] b, logic eob);
            byte_tag_t  t;
            logic [4:0] k;
            logic [1:0] err;
            bit         done;
            int         j;
            t.region = phase;
            err = ERR_NONE;
            done = 1'b0;
            k = byte_idx;
            case (phase)
                RGN_HEADER:
                begin
                    shift_reg = {b, shift_reg[31:8]};
                    byte_idx = k + 5'd1;
                    case (k)
                        POS_SIGNATURE:
                        begin
                            if (shift_reg != HDR_SIG)
                            begin
                                err = ERR_SIG;
                                phase = RGN_DISCARD;
                            end
                        end
                        POS_VERSION:
                        begin
                            version = shift_reg[31:16];
                            if (version > max_version)
                            begin
                                err = ERR_VERSION;
                                phase = RGN_DISCARD;
                            end
                        end
                        POS_FLAGS:     flags = shift_reg[31:16];
                        POS_METHOD:    method = shift_reg[31:16];
                        POS_CRC:       hdr_crc = shift_reg;
                        POS_CSIZE:     hdr_csize = shift_reg;
                        POS_USIZE:     hdr_usize = shift_reg;
                        POS_NAME_LEN:  name_len = shift_reg[31:16];
                        POS_EXTRA_LEN:
                        begin
                            extra_len = shift_reg[31:16];
                            mismatch = '0;
                            done = open_region(RGN_NAME);
                        end
                        default: ;
                    endcase
                    if (phase == RGN_DISCARD)
                        byte_idx = '0;
                end
                RGN_NAME, RGN_EXTRA, RGN_DATA:
                begin
                    skip_left = skip_left - 32'd1;
                    if (skip_left == 0)
                        done = open_region(region_t'(phase + 1));
                end
                RGN_DESC:
                begin
                    shift_reg = {b, shift_reg[31:8]};
                    if (k == 5'd3)
                        desc_sig_seen = (shift_reg == DESC_SIG);
                    // Field ends are counted after the signature when one was seen.
                    j = int'(k) + 1;
                    if (k >= 5'd3 && desc_sig_seen)
                        j -= int'(DESC_SIG_LEN);
                    if (k < 5'd3)
                        j = 0;
                    byte_idx = k + 5'd1;
                    if (j == int'(DESC_CRC_END))
                    begin
                        if (shift_reg != hdr_crc)
                            mismatch[0] = 1'b1;
                    end
                    else if (j == int'(DESC_CSIZE_END))
                    begin
                        if (shift_reg != hdr_csize)
                            mismatch[1] = 1'b1;
                    end
                    else if (j == int'(DESC_USIZE_END))
                    begin
                        if (shift_reg != hdr_usize)
                            mismatch[2] = 1'b1;
                        phase = RGN_HEADER;
                        byte_idx = '0;
                        shift_reg = '0;
                        done = 1'b1;
                    end
                end
                default:
                begin
                    t.region = RGN_DISCARD;
                    phase = RGN_DISCARD;
                end
            endcase

            if (eob)
            begin
                if (phase == RGN_DISCARD)
                begin
                    phase = RGN_HEADER;
                    byte_idx = '0;
                    shift_reg = '0;
                end
                else if (!done && !(phase == RGN_HEADER && byte_idx == 0))
                begin
                    if (err == ERR_NONE)
                        err = ERR_EOB;
                    phase = RGN_HEADER;
                    byte_idx = '0;
                    shift_reg = '0;
                    skip_left = '0;
                end
            end

            t.byte_out = b;
            t.done = done;
            t.err = err;
            t.crc_mm = done & mismatch[0];
            t.csize_mm = done & mismatch[1];
            t.usize_mm = done & mismatch[2];
            t.enc = flags[0];
            t.method = method;
            t.crc = hdr_crc;
            t.usize = hdr_usize;
            tags_due.push_back(t);
        endfunction

        function void check_tagged_byte(byte_tag_t got);
            byte_tag_t want;
            if (tags_due.size() == 0)
            begin
                flag_fault({"unexpected result: ", show(got)});
                return;
            end
            want = tags_due.pop_front();
            if (got.region !== want.region || got.byte_out !== want.byte_out ||
                got.done !== want.done || got.err !== want.err ||
                got.crc_mm !== want.crc_mm || got.csize_mm !== want.csize_mm ||
                got.usize_mm !== want.usize_mm || got.enc !== want.enc ||
                got.method !== want.method || got.crc !== want.crc ||
                got.usize !== want.usize)
                flag_fault({"mismatch\n  expected: ", show(want), "\n  actual:   ", show(got)});
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    byte_tag_scoreboard sb = new();
    stream_byte_t stim_q[$];
    stream_byte_t record_bytes[$];
    int burst_left = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    int seg_left = 0;
    int stall_pct = 0;
    bit long_hold_req = 1'b0;

    zip_local_header_parser_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: stall density changes per segment, with one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end
            seg_left--;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        byte_tag_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.region = region_t'(m_tuser);
            got.byte_out = m_tdata[7:0];
            got.done = m_tlast;
            got.err = m_tdata[9:8];
            got.crc_mm = m_tdata[10];
            got.csize_mm = m_tdata[11];
            got.usize_mm = m_tdata[12];
            got.enc = m_tdata[13];
            got.method = m_tdata[29:14];
            got.crc = m_tdata[61:30];
            got.usize = m_tdata[93:62];
            sb.check_tagged_byte(got);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_zip_local_header_parser_core failed");
            $finish;
        end
    end

    function automatic void push_le(logic [31:0] v, int n);
        stream_byte_t sbyte;
        for (int i = 0; i < n; i++)
        begin
            sbyte.data = v[8*i +: 8];
            sbyte.last = 1'b0;
            record_bytes.push_back(sbyte);
        end
    endfunction

    function automatic void push_random(int n);
        for (int i = 0; i < n; i++)
            push_le($urandom_range(0, 255), 1);
    endfunction

    function automatic logic [31:0] maybe_corrupt(logic [31:0] v);
        if ($urandom_range(0, 3) == 0)
            return v ^ (32'h1 << $urandom_range(0, 31));
        return v;
    endfunction

    function automatic record_spec_t base_record(logic [15:0] maxv);
        record_spec_t r;
        r.sig = HDR_SIG;
        r.version = 16'($urandom_range(0, maxv));
        r.flags = 16'($urandom);
        r.flags[3] = ($urandom_range(0, 2) == 0);
        r.method = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 9));
        r.crc = $urandom;
        r.csize = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 24);
        r.usize = $urandom;
        r.nlen = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
        r.elen = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 4));
        r.desc_sig = 1'($urandom_range(0, 1));
        r.d_crc = maybe_corrupt(r.crc);
        r.d_csize = maybe_corrupt(r.csize);
        r.d_usize = maybe_corrupt(r.usize);
        r.cut_at = CUT_NONE;
        r.eob_end = ($urandom_range(0, 4) == 0);
        return r;
    endfunction

    function automatic void emit_record(record_spec_t r);
        int cap;
        int cut;
        record_bytes.delete();
        push_le(r.sig, 4);
        push_le({16'h0, r.version}, 2);
        push_le({16'h0, r.flags}, 2);
        push_le({16'h0, r.method}, 2);
        push_le($urandom, 4);   // modification time and date
        push_le(r.crc, 4);
        push_le(r.csize, 4);
        push_le(r.usize, 4);
        push_le({16'h0, r.nlen}, 2);
        push_le({16'h0, r.elen}, 2);
        // A record that will be cut short never needs its full body.
        cap = (r.cut_at == CUT_RANDOM) ? 64 : 32'h3fff_ffff;
        push_random((r.nlen > cap) ? cap : int'(r.nlen));
        push_random((r.elen > cap) ? cap : int'(r.elen));
        push_random((r.csize > cap) ? cap : int'(r.csize));
        if (r.flags[3])
        begin
            if (r.desc_sig)
                push_le(DESC_SIG, 4);
            push_le(r.d_crc, 4);
            push_le(r.d_csize, 4);
            push_le(r.d_usize, 4);
        end
        cut = r.cut_at;
        if (cut == CUT_RANDOM)
            cut = $urandom_range(0, record_bytes.size() - 2);
        if (cut >= 0 && cut < record_bytes.size())
        begin
            while (record_bytes.size() > cut + 1)
                void'(record_bytes.pop_back());
            record_bytes[cut].last = 1'b1;
        end
        else if (r.eob_end)
            record_bytes[record_bytes.size() - 1].last = 1'b1;
        foreach (record_bytes[i])
            stim_q.push_back(record_bytes[i]);
    endfunction

    function automatic void push_noise(int n);
        record_bytes.delete();
        push_random(n);
        record_bytes[n - 1].last = 1'b1;
        foreach (record_bytes[i])
            stim_q.push_back(record_bytes[i]);
    endfunction

    task automatic send_byte(stream_byte_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= item.data;
        s_tlast <= item.last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input_byte(item.data, item.last);
    endtask

    // The closing cycle keeps the next run from driving s_tvalid in the same step.
    task automatic send_all();
        while (stim_q.size() != 0)
            send_byte(stim_q.pop_front());
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(output logic [31:0] rd);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_MAX_VERSION;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_write(logic [15:0] value);
        logic [31:0] rd;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_VERSION;
        pwdata <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.max_version = value;
        apb_read(rd);
        if (rd[15:0] !== value)
            sb.flag_fault($sformatf("max_version_needed reads %04h, expected %04h",
                                    rd[15:0], value));
    endtask

    task automatic wait_drained();
        while (sb.tags_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(int n_bytes, logic [15:0] maxv);
        record_spec_t r;
        int pick;
        while (stim_q.size() < n_bytes)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 96)
                push_noise($urandom_range(1, 12));
            else
            begin
                r = base_record(maxv);
                if (pick >= 75 && pick < 83)
                begin
                    r.sig ^= 32'h1 << $urandom_range(0, 31);
                    r.eob_end = 1'b1;
                end
                else if (pick >= 83 && pick < 88 && maxv != 16'hFFFF)
                begin
                    r.version = 16'($urandom_range(int'(maxv) + 1, 65535));
                    r.eob_end = 1'b1;
                end
                else if (pick >= 88)
                begin
                    // Truncated records may claim huge regions; the buffer end cuts them.
                    r.cut_at = CUT_RANDOM;
                    if ($urandom_range(0, 1))
                        r.csize = $urandom;
                    if ($urandom_range(0, 3) == 0)
                        r.nlen = 16'($urandom);
                end
                emit_record(r);
            end
        end
        send_all();
    endtask

    task automatic run_directed();
        record_spec_t r;
        // Minimal record: every region empty, ends on the last header byte.
        r = base_record(VERSION_RESET);
        r.version = VERSION_RESET;
        r.flags = 16'h0000;
        r.method = 16'h0000;
        r.crc = '0;
        r.csize = '0;
        r.usize = '0;
        r.nlen = '0;
        r.elen = '0;
        r.eob_end = 1'b0;
        emit_record(r);
        // All-ones fields with name, extra and data present.
        r.version = 16'd0;
        r.flags = 16'hFFF7;
        r.method = 16'hFFFF;
        r.crc = 32'hFFFF_FFFF;
        r.usize = 32'hFFFF_FFFF;
        r.nlen = 16'd3;
        r.elen = 16'd2;
        r.csize = 32'd5;
        emit_record(r);
        // Descriptor with signature, all fields matching.
        r = base_record(VERSION_RESET);
        r.flags = 16'h0008;
        r.nlen = 16'd1;
        r.elen = 16'd0;
        r.csize = 32'd4;
        r.desc_sig = 1'b1;
        r.d_crc = r.crc;
        r.d_csize = r.csize;
        r.d_usize = r.usize;
        r.eob_end = 1'b0;
        emit_record(r);
        // Descriptor without signature, every field wrong, buffer ends with the record.
        r.desc_sig = 1'b0;
        r.d_crc = ~r.crc;
        r.d_csize = ~r.csize;
        r.d_usize = ~r.usize;
        r.eob_end = 1'b1;
        emit_record(r);
        // Descriptor straight after the header.
        r = base_record(VERSION_RESET);
        r.flags = 16'h0009;
        r.nlen = '0;
        r.elen = '0;
        r.csize = '0;
        r.desc_sig = 1'b1;
        r.d_crc = r.crc;
        r.d_csize = r.csize;
        r.d_usize = r.usize;
        r.eob_end = 1'b0;
        emit_record(r);
        // Bad signature revealed on the same byte that ends the buffer.
        r = base_record(VERSION_RESET);
        r.sig = HDR_SIG ^ 32'h0100_0000;
        r.cut_at = 3;
        emit_record(r);
        // Bad signature, the rest of the record is discarded.
        r = base_record(VERSION_RESET);
        r.sig = 32'h0;
        r.eob_end = 1'b1;
        emit_record(r);
        // Version one above the limit.
        r = base_record(VERSION_RESET);
        r.version = VERSION_RESET + 16'd1;
        r.eob_end = 1'b1;
        emit_record(r);
        // Buffer ends in the middle of the data.
        r = base_record(VERSION_RESET);
        r.nlen = 16'd2;
        r.elen = 16'd1;
        r.csize = 32'd10;
        r.cut_at = 37;
        emit_record(r);
        // Descriptor CRC equal to the descriptor signature, sent without a signature.
        r = base_record(VERSION_RESET);
        r.flags = 16'h0008;
        r.desc_sig = 1'b0;
        r.d_crc = DESC_SIG;
        r.eob_end = 1'b1;
        emit_record(r);
        // Two stray bytes ending the buffer inside a header.
        push_noise(2);
        // Record that ends in its extra field.
        r = base_record(VERSION_RESET);
        r.flags = 16'h0000;
        r.nlen = '0;
        r.elen = 16'd3;
        r.csize = '0;
        r.eob_end = 1'b0;
        emit_record(r);
        send_all();
    endtask

    initial
    begin
        logic [31:0] rd;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_read(rd);
        if (rd[15:0] !== VERSION_RESET)
            sb.flag_fault($sformatf("max_version_needed reads %04h after reset", rd[15:0]));

        run_directed();
        run_random(250, VERSION_RESET);

        wait_drained();
        apb_write(16'h0000);
        run_random(200, 16'h0000);

        wait_drained();
        apb_write(16'hFFFF);
        run_random(200, 16'hFFFF);

        wait_drained();
        apb_write(16'($urandom_range(1, 65534)));
        long_hold_req = 1'b1;
        run_random(350, sb.max_version);

        wait_drained();
        if (sb.tags_due.size() != 0)
            sb.flag_fault($sformatf("%0d results never arrived", sb.tags_due.size()));
        if (sb.fault_count == 0)
            $display("tb_zip_local_header_parser_core passed");
        else
            $display("tb_zip_local_header_parser_core failed");
        $finish;
    end

endmodule

// ===== zip_local_header_parser_core.f =====
rtl/core/zlhp_pkg.sv
rtl/core/zip_local_header_parser_core.sv
tb/tb_zip_local_header_parser_core.sv
